// File: sv/bslpd_pkg.sv
// Shared types, register indexes and reset values for the button press detector.
package bslpd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned REG_WIDTH       = 16;
  localparam int unsigned REG_IDX_WIDTH   = 2;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_ACTIVE_LEVEL   = 2'd0,
    REG_DEBOUNCE_TICKS = 2'd1,
    REG_HOLD_TICKS     = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_e;

  localparam logic                 ACTIVE_LEVEL_RST   = 1'b0;
  localparam logic [REG_WIDTH-1:0] DEBOUNCE_TICKS_RST = 16'd50;
  localparam logic [REG_WIDTH-1:0] HOLD_TICKS_RST     = 16'd5000;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HELD     = 2'd2,
    PH_WAIT     = 2'd3
  } phase_e;

  typedef struct packed {
    logic                 active_level;
    logic [REG_WIDTH-1:0] debounce_ticks;
    logic [REG_WIDTH-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic held_now;
  } res_t;

endpackage

// File: sv/button_short_long_press_detector.sv
// Button press detector: one pin sample in per item, one result out per item, one item a
// cycle while the result side keeps up; a sample passes an input register, the phase logic
// and a result register, and its result is offered from the result register, so
// back-to-back samples stream at full rate. Each sample yields short_press, long_press
// and held_now. Registers (active level, debounce and hold lengths in sample ticks) are
// written through the plain write port and should only change while no item is in flight.
module button_short_long_press_detector #(
  parameter int unsigned COUNT_WIDTH = bslpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bslpd_pkg::REG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [bslpd_pkg::REG_WIDTH-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                pin_level_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                short_press_o,
  output logic                                long_press_o,
  output logic                                held_now_o
);

  bslpd_pkg::cfg_t   cfg;
  bslpd_pkg::phase_e phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  bslpd_pkg::res_t   res_d, res_q;
  logic s1_valid_q, pin_q, out_valid_q;
  logic out_free, s1_go, in_take;

  bslpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bslpd_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .phase_i   (phase_q),
    .count_i   (count_q),
    .pressed_i (pin_q == cfg.active_level),
    .cfg_i     (cfg),
    .phase_o   (phase_d),
    .count_o   (count_d),
    .res_o     (res_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= bslpd_pkg::PH_IDLE;
      count_q     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        count_q     <= count_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pin_q <= pin_level_i;
    end
    if (s1_go) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign short_press_o = res_q.short_press;
  assign long_press_o  = res_q.long_press;
  assign held_now_o    = res_q.held_now;

`ifndef SYNTHESIS
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(short_press_o && long_press_o))
    else $error("short and long press in the same item");

  a_long_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && long_press_o) |-> !held_now_o)
    else $error("long press reported while still held");

  a_held_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> (held_now_o == (phase_q == bslpd_pkg::PH_HELD)))
    else $error("held flag disagrees with phase");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bslpd_pkg::PH_IDLE) |-> (count_q == '0))
    else $error("tick count not cleared in idle");
`endif

endmodule

// File: sv/bslpd_cfg.sv
// Configuration registers of the button press detector.
module bslpd_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bslpd_pkg::REG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [bslpd_pkg::REG_WIDTH-1:0]      cfg_wdata_i,
  output bslpd_pkg::cfg_t                      cfg_o
);

  bslpd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bslpd_pkg::reg_idx_e'(cfg_index_i))
        bslpd_pkg::REG_ACTIVE_LEVEL:   cfg_d.active_level   = cfg_wdata_i[0];
        bslpd_pkg::REG_DEBOUNCE_TICKS: cfg_d.debounce_ticks = cfg_wdata_i;
        bslpd_pkg::REG_HOLD_TICKS:     cfg_d.hold_ticks     = cfg_wdata_i;
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level   <= bslpd_pkg::ACTIVE_LEVEL_RST;
      cfg_q.debounce_ticks <= bslpd_pkg::DEBOUNCE_TICKS_RST;
      cfg_q.hold_ticks     <= bslpd_pkg::HOLD_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/bslpd_step.sv
// Next phase, next count and result flags for one pin sample.
module bslpd_step #(
  parameter int unsigned COUNT_WIDTH = bslpd_pkg::COUNT_WIDTH_DEF
) (
  input  bslpd_pkg::phase_e        phase_i,
  input  logic [COUNT_WIDTH-1:0]   count_i,
  input  logic                     pressed_i,
  input  bslpd_pkg::cfg_t          cfg_i,
  output bslpd_pkg::phase_e        phase_o,
  output logic [COUNT_WIDTH-1:0]   count_o,
  output bslpd_pkg::res_t          res_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > bslpd_pkg::REG_WIDTH) ?
                                 COUNT_WIDTH : bslpd_pkg::REG_WIDTH;

  logic                   count_max;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [CmpW-1:0]        count_w, inc_w, deb_w, hold_w;
  logic                   deb_done;

  assign count_max = (count_i == {COUNT_WIDTH{1'b1}});
  assign count_inc = count_max ? count_i : count_i + 1'b1;
  assign count_w   = CmpW'(count_i);
  assign inc_w     = CmpW'(count_inc);
  assign deb_w     = CmpW'(cfg_i.debounce_ticks);
  assign hold_w    = CmpW'(cfg_i.hold_ticks);
  // a saturated counter also ends the wait when the debounce length cannot be reached
  assign deb_done  = (count_w >= deb_w) || count_max;

  always_comb begin
    phase_o           = phase_i;
    count_o           = count_i;
    res_o.short_press = 1'b0;
    res_o.long_press  = 1'b0;
    case (phase_i)
      bslpd_pkg::PH_IDLE: begin
        if (pressed_i) begin
          phase_o = bslpd_pkg::PH_DEBOUNCE;
          count_o = '0;
        end
      end
      bslpd_pkg::PH_DEBOUNCE: begin
        if (!deb_done) begin
          count_o = count_inc;
        end else begin
          phase_o = pressed_i ? bslpd_pkg::PH_HELD : bslpd_pkg::PH_IDLE;
          count_o = '0;
        end
      end
      bslpd_pkg::PH_HELD: begin
        if (pressed_i) begin
          count_o = count_inc;
          if (inc_w >= hold_w) begin
            res_o.long_press = 1'b1;
            phase_o          = bslpd_pkg::PH_WAIT;
            count_o          = '0;
          end
        end else begin
          res_o.short_press = (inc_w >= deb_w) && (inc_w < hold_w);
          phase_o           = bslpd_pkg::PH_IDLE;
          count_o           = '0;
        end
      end
      default: begin
        if (!pressed_i) begin
          phase_o = bslpd_pkg::PH_IDLE;
          count_o = '0;
        end
      end
    endcase
    res_o.held_now = (phase_o == bslpd_pkg::PH_HELD);
  end

endmodule
